// ===== rtl/core/lfsq_pkg.sv =====
package lfsq_pkg;

  localparam int unsigned MaxCols   = 1024;
  localparam int unsigned MaxRows   = 4096;
  localparam int unsigned ColW      = $clog2(MaxCols);
  localparam int unsigned RowW      = $clog2(MaxRows);
  localparam int unsigned SizeW     = ColW + 1;
  localparam int unsigned NumColsW  = 11;
  localparam int unsigned NumRowsW  = 13;
  localparam int unsigned CharW     = 8;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;
  localparam logic [CharW-1:0] ObstacleRst = CharW'(111);

  typedef enum logic [1:0] {
    REG_NUM_COLS      = 2'd0,
    REG_NUM_ROWS      = 2'd1,
    REG_OBSTACLE_CHAR = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  typedef logic [SizeW-1:0] size_t;

  function automatic size_t min3(size_t a, size_t b, size_t c);
    size_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

// ===== rtl/core/largest_free_square_finder.sv =====
// Channel   Direction  Handshake                  Payload
// in_       in         in_valid / in_ready        in_cell_char
// out_      out        out_valid / out_ready      out_square_size, out_top_row, out_left_col
// cfg       in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item per cycle sustained; the line store is read at the edge that accepts
// an item and the size is updated from the stage 1 registers, so the result
// register loads when the last cell of a map leaves stage 1. The line store is a
// single-port-write, one-read memory of MaxCols entries. Reset is synchronous
// and clears counters, best square and the result valid flag; the line store is
// not cleared. The input stalls only when the last cell of a map is pending and
// the result register is still held.
module largest_free_square_finder
  import lfsq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CharW-1:0]    in_cell_char,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SizeW-1:0]    out_square_size,
  output logic [RowW-1:0]     out_top_row,
  output logic [ColW-1:0]     out_left_col,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  logic [NumColsW-1:0] num_cols_r;
  logic [NumRowsW-1:0] num_rows_r;
  logic [CharW-1:0]    obstacle_r;

  logic [ColW-1:0]     col_r, col_nxt;
  logic [RowW-1:0]     row_r, row_nxt;

  logic [SizeW-1:0]    line_mem [MaxCols];
  logic [SizeW-1:0]    mem_rdata_r;

  logic                s1_valid_r;
  logic                s1_blocked_r;
  logic                s1_edge_r;
  logic                s1_last_col_r;
  logic                s1_last_r;
  logic [ColW-1:0]     s1_col_r;
  logic [RowW-1:0]     s1_row_r;
  logic                fwd_r;
  logic [SizeW-1:0]    fwd_data_r;

  logic [SizeW-1:0]    left_r, left_nxt;
  logic [SizeW-1:0]    diag_r, diag_nxt;
  logic [SizeW-1:0]    best_size_r, best_size_nxt;
  logic [RowW-1:0]     best_row_r, best_row_nxt;
  logic [ColW-1:0]     best_col_r, best_col_nxt;

  logic                out_valid_r;
  logic [SizeW-1:0]    out_size_r;
  logic [RowW-1:0]     out_row_r;
  logic [ColW-1:0]     out_col_r;

  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic [NumColsW-1:0] cols_eff;
  logic [NumRowsW-1:0] rows_eff;
  logic                last_col, last_row;
  logic                accept, s1_fire;
  logic [SizeW-1:0]    up;
  logic [SizeW-1:0]    size;
  logic [RowW:0]       row_span;
  logic [ColW:0]       col_span;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= NumColsW'(1);
      num_rows_r <= NumRowsW'(1);
      obstacle_r <= ObstacleRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NUM_COLS:      num_cols_r <= pwdata[NumColsW-1:0];
        REG_NUM_ROWS:      num_rows_r <= pwdata[NumRowsW-1:0];
        REG_OBSTACLE_CHAR: obstacle_r <= pwdata[CharW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NUM_COLS:      prdata = DataW'(num_cols_r);
      REG_NUM_ROWS:      prdata = DataW'(num_rows_r);
      REG_OBSTACLE_CHAR: prdata = DataW'(obstacle_r);
      default:           prdata = '0;
    endcase
  end

  // effective map size
  always_comb begin
    if (num_cols_r == '0)                     cols_eff = NumColsW'(1);
    else if (num_cols_r > NumColsW'(MaxCols)) cols_eff = NumColsW'(MaxCols);
    else                                      cols_eff = num_cols_r;
    if (num_rows_r == '0)                     rows_eff = NumRowsW'(1);
    else if (num_rows_r > NumRowsW'(MaxRows)) rows_eff = NumRowsW'(MaxRows);
    else                                      rows_eff = num_rows_r;
  end

  assign last_col = (NumColsW'({1'b0, col_r} + (ColW+1)'(1)) >= cols_eff);
  assign last_row = (NumRowsW'({1'b0, row_r} + (RowW+1)'(1)) >= rows_eff);

  // handshake
  assign s1_fire  = s1_valid_r && !(s1_last_r && out_valid_r && !out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign accept   = in_valid && in_ready;

  // scan counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (!last_col) begin
        col_nxt = col_r + ColW'(1);
      end else begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store: read at accept, write back at update
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_rdata_r <= line_mem[col_r];
    end
    if (s1_fire) begin
      line_mem[s1_col_r] <= size;
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= s1_fire && (s1_col_r == col_r);
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_blocked_r  <= (in_cell_char == obstacle_r);
      s1_edge_r     <= (col_r == '0) || (row_r == '0);
      s1_last_col_r <= last_col;
      s1_last_r     <= last_col && last_row;
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
      fwd_data_r    <= size;
    end
  end

  // size update
  assign up = fwd_r ? fwd_data_r : mem_rdata_r;

  always_comb begin
    if (s1_blocked_r)   size = '0;
    else if (s1_edge_r) size = SizeW'(1);
    else                size = min3(up, left_r, diag_r) + SizeW'(1);
  end

  assign row_span = {1'b0, s1_row_r} + (RowW+1)'(1);
  assign col_span = {1'b0, s1_col_r} + (ColW+1)'(1);

  always_comb begin
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    best_size_nxt = best_size_r;
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;
    if (s1_fire) begin
      if (size > best_size_r) begin
        best_size_nxt = size;
        best_row_nxt  = ((RowW+1)'(size) > row_span) ? '0
                        : RowW'(row_span - (RowW+1)'(size));
        best_col_nxt  = ((ColW+1)'(size) > col_span) ? '0
                        : ColW'(col_span - (ColW+1)'(size));
      end
      left_nxt = s1_last_col_r ? '0 : size;
      diag_nxt = s1_last_col_r ? '0 : up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (s1_fire && s1_last_r) begin
      left_r      <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else begin
      left_r      <= left_nxt;
      diag_r      <= diag_nxt;
      best_size_r <= best_size_nxt;
      best_row_r  <= best_row_nxt;
      best_col_r  <= best_col_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_size_r <= best_size_nxt;
      out_row_r  <= best_row_nxt;
      out_col_r  <= best_col_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_square_size = out_size_r;
  assign out_top_row     = out_row_r;
  assign out_left_col    = out_col_r;

  a_stall_needs_result : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |-> out_valid_r && s1_last_r)
    else $error("update stage stalled without a held result");

  a_no_accept_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !s1_valid_r || s1_fire)
    else $error("item accepted while update stage stalled");

  a_best_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> best_size_r == '0 && left_r == '0 && diag_r == '0)
    else $error("best square not cleared after map end");

  a_fwd_on_same_col : assert property (@(posedge clk) disable iff (!rst_n)
    accept && s1_fire && (s1_col_r == col_r) |=> fwd_r)
    else $error("line data not forwarded for a back-to-back item on the same column");

endmodule
